// ===== hw/rtl/bdb_pkg.sv =====
// box distance bounds: shared widths, result record, root step type and state codes
// no dependencies
package bdb_pkg;

    localparam int SUM_W       = 54;
    localparam int ROOT_W      = 27;
    localparam int REM_W       = ROOT_W + 3;
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef struct packed {
        logic [SUM_W-1:0] min_sum;
        logic [SUM_W-1:0] max_sum;
    } sums_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } root_step_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_RUN,
        SQ_DONE
    } sqrt_state_t;

endpackage

// ===== hw/rtl/box_distance_bounds_top.sv =====
// box distance bounds top: least and greatest squared distance between two boxes and roots
// depends on bdb_pkg, bdb_front, bdb_queue, bdb_sqrt
// takes one dimension per cycle unless in_stall is high; the front runs three stages
// (bounds, squares, running sums); the 27-step root unit handles one box pair at a time,
// two pairs wait in the queue before input stalls
// rst_n clears the sums, the queue and all valid flags at once; no clearing pass
module box_distance_bounds_top #(
    parameter int COORD_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [COORD_BITS-1:0]       a_low,
    input  logic signed [COORD_BITS-1:0]       a_high,
    input  logic signed [COORD_BITS-1:0]       b_low,
    input  logic signed [COORD_BITS-1:0]       b_high,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [bdb_pkg::SUM_W-1:0]          min_sq_dist,
    output logic [bdb_pkg::SUM_W-1:0]          max_sq_dist,
    output logic [bdb_pkg::ROOT_W-1:0]         min_dist,
    output logic [bdb_pkg::ROOT_W-1:0]         max_dist
);
    import bdb_pkg::*;

    logic  q_full;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    sums_t q_push_data;
    sums_t q_pop_data;

    bdb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_low       (a_low),
        .a_high      (a_high),
        .b_low       (b_low),
        .b_high      (b_high),
        .last        (last),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    bdb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_pop_data)
    );

    bdb_sqrt u_sqrt (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_pop_data),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_sq_dist (min_sq_dist),
        .max_sq_dist (max_sq_dist),
        .min_dist    (min_dist),
        .max_dist    (max_dist)
    );

endmodule

// ===== hw/rtl/bdb_front.sv =====
// box distance bounds front: per-dimension gap and span, saturated squares, running sums
// depends on bdb_pkg; pushes finished sum pairs into bdb_queue
module bdb_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] a_low,
    input  logic signed [COORD_BITS-1:0] a_high,
    input  logic signed [COORD_BITS-1:0] b_low,
    input  logic signed [COORD_BITS-1:0] b_high,
    input  logic                         last,
    input  logic                         q_full,
    output logic                         q_push,
    output bdb_pkg::sums_t               q_push_data
);
    import bdb_pkg::*;

    localparam int EXT_W = (COORD_BITS > ROOT_W) ? COORD_BITS : ROOT_W + 1;

    logic signed [COORD_BITS:0] al;
    logic signed [COORD_BITS:0] ah;
    logic signed [COORD_BITS:0] bl;
    logic signed [COORD_BITS:0] bh;
    logic signed [COORD_BITS:0] gap_w;
    logic signed [COORD_BITS:0] s1_w;
    logic signed [COORD_BITS:0] s2_w;
    logic signed [COORD_BITS:0] span_w;

    logic                  adv;
    logic                  a_valid_reg;
    logic                  a_last_reg;
    logic [COORD_BITS-1:0] gap_reg;
    logic [COORD_BITS-1:0] span_reg;

    logic [EXT_W-1:0]  gap_ext;
    logic [EXT_W-1:0]  span_ext;
    logic [ROOT_W-1:0] gap_op;
    logic [ROOT_W-1:0] span_op;
    logic [SUM_W-1:0]  gap_prod;
    logic [SUM_W-1:0]  span_prod;
    logic [SUM_W-1:0]  min_sq_next;
    logic [SUM_W-1:0]  max_sq_next;

    logic             b_valid_reg;
    logic             b_last_reg;
    logic [SUM_W-1:0] min_sq_reg;
    logic [SUM_W-1:0] max_sq_reg;

    logic [SUM_W:0]   min_add;
    logic [SUM_W:0]   max_add;
    logic [SUM_W-1:0] min_sum_next;
    logic [SUM_W-1:0] max_sum_next;
    logic [SUM_W-1:0] min_sum_reg;
    logic [SUM_W-1:0] max_sum_reg;

    // stage a: interval gap and largest span
    assign al = {a_low[COORD_BITS-1], a_low};
    assign ah = {a_high[COORD_BITS-1], a_high};
    assign bl = {b_low[COORD_BITS-1], b_low};
    assign bh = {b_high[COORD_BITS-1], b_high};

    always_comb
    begin
        if (al > bh)
        begin
            gap_w = al - bh;
        end
        else if (bl > ah)
        begin
            gap_w = bl - ah;
        end
        else
        begin
            gap_w = '0;
        end
        s1_w   = (ah >= bl) ? (ah - bl) : (bl - ah);
        s2_w   = (bh >= al) ? (bh - al) : (al - bh);
        span_w = (s1_w > s2_w) ? s1_w : s2_w;
    end

    assign adv      = !(b_valid_reg && b_last_reg && q_full);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_last_reg <= last;
            gap_reg    <= gap_w[COORD_BITS-1:0];
            span_reg   <= span_w[COORD_BITS-1:0];
            b_last_reg <= a_last_reg;
            min_sq_reg <= min_sq_next;
            max_sq_reg <= max_sq_next;
        end
    end

    // stage b: saturated squares
    assign gap_ext   = EXT_W'(gap_reg);
    assign span_ext  = EXT_W'(span_reg);
    assign gap_op    = gap_ext[ROOT_W-1:0];
    assign span_op   = span_ext[ROOT_W-1:0];
    assign gap_prod  = gap_op * gap_op;
    assign span_prod = span_op * span_op;

    assign min_sq_next = (|gap_ext[EXT_W-1:ROOT_W]) ? SUM_MAX : gap_prod;
    assign max_sq_next = (|span_ext[EXT_W-1:ROOT_W]) ? SUM_MAX : span_prod;

    // accumulate with saturation
    assign min_add      = {1'b0, min_sum_reg} + {1'b0, min_sq_reg};
    assign max_add      = {1'b0, max_sum_reg} + {1'b0, max_sq_reg};
    assign min_sum_next = min_add[SUM_W] ? SUM_MAX : min_add[SUM_W-1:0];
    assign max_sum_next = max_add[SUM_W] ? SUM_MAX : max_add[SUM_W-1:0];

    assign q_push              = adv && b_valid_reg && b_last_reg;
    assign q_push_data.min_sum = min_sum_next;
    assign q_push_data.max_sum = max_sum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sum_reg <= '0;
            max_sum_reg <= '0;
        end
        else if (adv && b_valid_reg)
        begin
            if (b_last_reg)
            begin
                min_sum_reg <= '0;
                max_sum_reg <= '0;
            end
            else
            begin
                min_sum_reg <= min_sum_next;
                max_sum_reg <= max_sum_next;
            end
        end
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (b_valid_reg && b_last_reg && q_full))
        else $error("front stalled without a blocked last item");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (min_sum_reg == '0 && max_sum_reg == '0))
        else $error("sums not cleared after push");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> (b_valid_reg && $stable(min_sum_reg) && $stable(max_sum_reg)))
        else $error("sums moved while stalled");

endmodule

// ===== hw/rtl/bdb_queue.sv =====
// box distance bounds: short queue of finished sum pairs between front and root unit
// depends on bdb_pkg
module bdb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bdb_pkg::sums_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output bdb_pkg::sums_t pop_data
);
    import bdb_pkg::*;

    sums_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full      = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

// ===== hw/rtl/bdb_sqrt.sv =====
// box distance bounds back end: two-lane digit-by-digit floor square root and output register
// depends on bdb_pkg; takes sum pairs from bdb_queue
module bdb_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  bdb_pkg::sums_t              q_data,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bdb_pkg::SUM_W-1:0]   min_sq_dist,
    output logic [bdb_pkg::SUM_W-1:0]   max_sq_dist,
    output logic [bdb_pkg::ROOT_W-1:0]  min_dist,
    output logic [bdb_pkg::ROOT_W-1:0]  max_dist
);
    import bdb_pkg::*;

    sqrt_state_t state_reg;
    sqrt_state_t state_next;

    logic       load;
    logic       step;
    logic       emit;
    logic       out_valid_reg;
    logic [CNT_W-1:0] cnt_reg;

    sums_t             sums_reg;
    logic [SUM_W-1:0]  min_v_reg;
    logic [SUM_W-1:0]  max_v_reg;
    logic [REM_W-1:0]  min_rem_reg;
    logic [REM_W-1:0]  max_rem_reg;
    logic [ROOT_W-1:0] min_root_reg;
    logic [ROOT_W-1:0] max_root_reg;
    root_step_t        min_step;
    root_step_t        max_step;

    logic [SUM_W-1:0]  min_sq_dist_reg;
    logic [SUM_W-1:0]  max_sq_dist_reg;
    logic [ROOT_W-1:0] min_dist_reg;
    logic [ROOT_W-1:0] max_dist_reg;

    function automatic root_step_t sqrt_step(
        input logic [REM_W-1:0]  rem,
        input logic [ROOT_W-1:0] root,
        input logic [1:0]        pair
    );
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        root_step_t       r;
        cur   = {rem[REM_W-3:0], pair};
        trial = REM_W'({root, 2'b01});
        if (cur >= trial)
        begin
            r.rem  = cur - trial;
            r.root = {root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = cur;
            r.root = {root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load       = 1'b0;
        step       = 1'b0;
        emit       = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (q_valid)
                begin
                    load       = 1'b1;
                    state_next = SQ_RUN;
                end
            end
            SQ_RUN:
            begin
                step = 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    state_next = SQ_DONE;
                end
            end
            SQ_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit       = 1'b1;
                    state_next = SQ_IDLE;
                end
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    assign q_pop    = load;
    assign min_step = sqrt_step(min_rem_reg, min_root_reg, min_v_reg[SUM_W-1:SUM_W-2]);
    assign max_step = sqrt_step(max_rem_reg, max_root_reg, max_v_reg[SUM_W-1:SUM_W-2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= '0;
        end
        else if (step)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sums_reg     <= q_data;
            min_v_reg    <= q_data.min_sum;
            max_v_reg    <= q_data.max_sum;
            min_rem_reg  <= '0;
            max_rem_reg  <= '0;
            min_root_reg <= '0;
            max_root_reg <= '0;
        end
        else if (step)
        begin
            min_v_reg    <= {min_v_reg[SUM_W-3:0], 2'b00};
            max_v_reg    <= {max_v_reg[SUM_W-3:0], 2'b00};
            min_rem_reg  <= min_step.rem;
            max_rem_reg  <= max_step.rem;
            min_root_reg <= min_step.root;
            max_root_reg <= max_step.root;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            min_sq_dist_reg <= sums_reg.min_sum;
            max_sq_dist_reg <= sums_reg.max_sum;
            min_dist_reg    <= min_root_reg;
            max_dist_reg    <= max_root_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign min_sq_dist = min_sq_dist_reg;
    assign max_sq_dist = max_sq_dist_reg;
    assign min_dist    = min_dist_reg;
    assign max_dist    = max_dist_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_RUN) |-> (cnt_reg <= CNT_W'(ROOT_W - 1)))
        else $error("root step count out of range");

    a_emit_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && state_reg == SQ_IDLE))
        else $error("result not presented after root finished");

    a_full_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SQ_DONE) |-> (cnt_reg == CNT_W'(ROOT_W)))
        else $error("root finished early");

endmodule

// ===== tb/tb.sv =====
// tb: stimulus, running distance-bound predictor and result checker for box_distance_bounds_top
// depends on bdb_pkg and box_distance_bounds_top; needs no files or arguments
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bdb_pkg::*;

    localparam int COORD_W = 24;
    localparam int CMAX = (1 << (COORD_W - 1)) - 1;
    localparam int CMIN = -(1 << (COORD_W - 1));
    localparam int REPORT_LIMIT = 10;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic [SUM_W-1:0]  min_sq;
        logic [SUM_W-1:0]  max_sq;
        logic [ROOT_W-1:0] min_rt;
        logic [ROOT_W-1:0] max_rt;
    } bounds_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    coord_t             a_low;
    coord_t             a_high;
    coord_t             b_low;
    coord_t             b_high;
    logic               last;
    logic               out_valid;
    logic               out_stall;
    logic [SUM_W-1:0]   min_sq_dist;
    logic [SUM_W-1:0]   max_sq_dist;
    logic [ROOT_W-1:0]  min_dist;
    logic [ROOT_W-1:0]  max_dist;

    bounds_t            expected_bounds[$];
    logic [SUM_W-1:0]   gap_sum;
    logic [SUM_W-1:0]   span_sum;
    int                 mismatches;
    int                 dims_sent;
    int                 pairs_checked;
    int                 saturated_pairs;
    int                 hold_left;
    int                 stall_mode;
    int                 gap_mode;
    int                 burst_left;

    box_distance_bounds_top #(.COORD_BITS(COORD_W)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .a_low       (a_low),
        .a_high      (a_high),
        .b_low       (b_low),
        .b_high      (b_high),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .min_sq_dist (min_sq_dist),
        .max_sq_dist (max_sq_dist),
        .min_dist    (min_dist),
        .max_dist    (max_dist)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    initial
    begin
        #1_500_000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [ROOT_W-1:0] floor_root(logic [SUM_W-1:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = 64'd0;
        for (int b = ROOT_W - 1; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= {10'd0, v})
                r = t;
        end
        return r[ROOT_W-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] add_sat(logic [SUM_W-1:0] s, logic [63:0] t);
        logic [63:0] r;
        r = {10'd0, s} + t;
        return (r > {10'd0, SUM_MAX}) ? SUM_MAX : r[SUM_W-1:0];
    endfunction

    function automatic coord_t rand_coord();
        case ($urandom_range(0, 7))
            0:       return coord_t'(CMIN);
            1:       return coord_t'(CMAX);
            2:       return coord_t'(int'($urandom_range(0, 200)) - 100);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // adds one dimension to the running sums, queues the bounds on the final one
    task automatic predict_dimension(coord_t al, coord_t ah, coord_t bl, coord_t bh, logic lst);
        longint xal;
        longint xah;
        longint xbl;
        longint xbh;
        longint gap;
        longint d1;
        longint d2;
        longint span;
        bounds_t b;
        xal = al;
        xah = ah;
        xbl = bl;
        xbh = bh;
        if (xal > xbh)
            gap = xal - xbh;
        else if (xbl > xah)
            gap = xbl - xah;
        else
            gap = 0;
        d1 = (xah >= xbl) ? xah - xbl : xbl - xah;
        d2 = (xbh >= xal) ? xbh - xal : xal - xbh;
        span = (d1 > d2) ? d1 : d2;
        gap_sum = add_sat(gap_sum, 64'(gap * gap));
        span_sum = add_sat(span_sum, 64'(span * span));
        if (lst)
        begin
            b.min_sq = gap_sum;
            b.max_sq = span_sum;
            b.min_rt = floor_root(gap_sum);
            b.max_rt = floor_root(span_sum);
            if (gap_sum == SUM_MAX || span_sum == SUM_MAX)
                saturated_pairs++;
            expected_bounds.push_back(b);
            gap_sum = '0;
            span_sum = '0;
        end
    endtask

    // offers one dimension request, with bursts and gaps from gap_mode
    task automatic send_dim(coord_t al, coord_t ah, coord_t bl, coord_t bh, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = (gap_mode == 0) ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                a_low = coord_t'($urandom);
                a_high = coord_t'($urandom);
                b_low = coord_t'($urandom);
                b_high = coord_t'($urandom);
                last = 1'($urandom);
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        a_low = al;
        a_high = ah;
        b_low = bl;
        b_high = bh;
        last = lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_dimension(al, ah, bl, bh, lst);
        dims_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (expected_bounds.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        stall_mode = 0;
        gap_mode = 0;
        // point inside, left of and right of a box
        send_dim(5, 5, 0, 10, 1'b1);
        send_dim(-100, -100, 50, 60, 1'b1);
        send_dim(1000, 1000, -3, 7, 1'b1);
        // three dimensions (two disjoint, then a point), then two overlapping dimensions
        send_dim(0, 10, 20, 30, 1'b0);
        send_dim(-50, -40, -10, 0, 1'b0);
        send_dim(7, 7, 7, 7, 1'b1);
        send_dim(0, 10, 5, 15, 1'b0);
        send_dim(-5, 5, -5, 5, 1'b1);
        // coordinate extremes
        send_dim(CMIN, CMIN, CMAX, CMAX, 1'b1);
        send_dim(CMAX, CMAX, CMIN, CMIN, 1'b1);
        send_dim(CMIN, CMAX, CMIN, CMAX, 1'b1);
        // inverted intervals
        send_dim(10, 0, 20, 15, 1'b1);
        send_dim(0, -20, -5, -30, 1'b1);
        // zero, touching, unit gap, all ones
        send_dim(0, 0, 0, 0, 1'b1);
        send_dim(0, 10, 10, 20, 1'b1);
        send_dim(0, 10, 11, 20, 1'b1);
        send_dim(-1, -1, 0, 0, 1'b1);
        send_dim(CMAX, CMAX, CMIN, CMIN, 1'b0);
        send_dim(CMIN, CMIN, CMAX, CMAX, 1'b1);
        wait_drained();
    endtask

    task automatic test_saturation();
        stall_mode = 1;
        gap_mode = 1;
        // 64 widest dimensions stay just below the ceiling, 65 reach it
        for (int i = 0; i < 64; i++)
            send_dim(CMAX, CMAX, CMIN, CMIN, i == 63);
        for (int i = 0; i < 65; i++)
            send_dim(CMIN, CMIN, CMAX, CMAX, i == 64);
        for (int i = 0; i < 70; i++)
            send_dim(CMIN, CMAX, CMAX, CMIN, i == 69);
        // sums start again from zero after a saturated pair
        send_dim(1, 1, 3, 3, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        stall_mode = 0;
        gap_mode = 0;
        hold_left = 400;
        for (int i = 0; i < 40; i++)
            send_dim(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b1);
        // sender pauses until everything has come back
        wait_drained();
        for (int i = 0; i < 10; i++)
            send_dim(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i % 3 == 2);
        send_dim(0, 0, 0, 0, 1'b1);
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        int dims;
        coord_t al;
        coord_t ah;
        coord_t bl;
        coord_t bh;
        coord_t t;
        for (int phase = 0; phase < 4; phase++)
        begin
            stall_mode = phase % 3;
            gap_mode = (phase == 0) ? 0 : 1;
            n = 0;
            while (n < 290)
            begin
                dims = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 80)
                                                   : $urandom_range(1, 6);
                for (int d = 0; d < dims; d++)
                begin
                    al = rand_coord();
                    ah = rand_coord();
                    bl = rand_coord();
                    bh = rand_coord();
                    if ($urandom_range(0, 9) != 0)
                    begin
                        if (al > ah)
                        begin
                            t = al;
                            al = ah;
                            ah = t;
                        end
                        if (bl > bh)
                        begin
                            t = bl;
                            bl = bh;
                            bh = t;
                        end
                    end
                    if ($urandom_range(0, 4) == 0)
                        ah = al;
                    send_dim(al, ah, bl, bh, d == dims - 1);
                    n++;
                end
            end
            wait_drained();
        end
    endtask

    // receiver stall pattern, plus the long hold-off
    initial
    begin
        int phase_cnt;
        phase_cnt = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            phase_cnt++;
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
            begin
                case (stall_mode)
                    0:       out_stall = 1'b0;
                    1:       out_stall = ($urandom_range(0, 99) < 35);
                    default: out_stall = ((phase_cnt % 11) < 6);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        bounds_t got;
        bounds_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {min_sq_dist, max_sq_dist, min_dist, max_dist};
            if (expected_bounds.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("unexpected result min_sq %0d max_sq %0d min %0d max %0d",
                             got.min_sq, got.max_sq, got.min_rt, got.max_rt);
                mismatches++;
            end
            else
            begin
                want = expected_bounds.pop_front();
                pairs_checked++;
                if (got !== want)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("mismatch min_sq exp %0d got %0d, max_sq exp %0d got %0d",
                                 want.min_sq, got.min_sq, want.max_sq, got.max_sq);
                        $display("         min exp %0d got %0d, max exp %0d got %0d",
                                 want.min_rt, got.min_rt, want.max_rt, got.max_rt);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        a_low = '0;
        a_high = '0;
        b_low = '0;
        b_high = '0;
        last = 1'b0;
        gap_sum = '0;
        span_sum = '0;
        mismatches = 0;
        dims_sent = 0;
        pairs_checked = 0;
        saturated_pairs = 0;
        hold_left = 0;
        stall_mode = 0;
        gap_mode = 0;
        burst_left = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_saturation();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (40) @(posedge clk);
        $display("covered %0d dimensions and %0d box pairs, %0d of them with a saturated sum",
                 dims_sent, pairs_checked, saturated_pairs);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
